// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files of the servo frame receiver.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== hdl/rsfr_pkg.sv =====
// Shared constants and controller/datapath interface types for the servo frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package rsfr_pkg;

    localparam int NumChannelsDefault = 14;
    localparam int PayloadLen        = 28;
    localparam int PayloadIdxW       = 5;
    localparam int ChanIdxW          = 4;
    localparam int OutDataW          = 80;

    localparam logic [7:0]  LEN_BYTE   = 8'h20;
    localparam logic [7:0]  TYPE_BYTE  = 8'h40;
    localparam logic [15:0] SUM_START  = 16'hFFFF;
    localparam logic [7:0]  SUM_LO_OK  = 8'h00;
    localparam logic [16:0] SCALE_BIAS = 17'd1500;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_GAP  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // input beat taken this cycle
        logic rd;          // read one channel's payload bytes
        logic load_single; // load a status-only result
        logic load_chan;   // load a channel result
        logic next_idx;    // advance channel index
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic good_frame;  // current input byte completes a good frame
        logic idx_last;    // channel index is the final one
        logic out_free;    // output register can take a result
    } status_t;

endpackage

// ===== hdl/rc_servo_frame_receiver_core.sv =====
// Top level of the servo frame receiver: joins the sequencing controller and the datapath.
// Depends on rsfr_pkg, rsfr_ctrl and rsfr_datapath.
//
//  Channel | Ports       | Beat contents
//  --------+-------------+----------------------------------------------------
//  input   | s_t*        | one received byte or one line-gap event
//  result  | m_t*        | frame status and counters, plus one channel if valid
//
// A beat is accepted in S_IDLE and its status result loads in S_PUT1 once the sink
// is free. A good frame's last byte instead emits NUM_CHANNELS results, each a memory
// read (S_READ) then an output load (S_PUTC). s_tready is low until the beat's last
// result is loaded; a stalled sink stretches every load. Reset is synchronous; the
// payload memory needs no clearing.
`timescale 1ns / 1ps

module rc_servo_frame_receiver_core
    import rsfr_pkg::*;
#(
    parameter int NUM_CHANNELS = NumChannelsDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic [0:0]          s_tuser,   // [0] func (1 = frame gap)
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] frame_ok, [1] checksum_error, [17:2] frames_seen, [33:18] frames_good,
    // [49:34] checksum_failures, [53:50] channel_index, [69:54] channel_raw,
    // [77:70] channel_scaled, [79:78] zero
    output logic [OutDataW-1:0] m_tdata,
    output logic [0:0]          m_tuser,   // [0] channel_valid
    output logic                m_tlast    // last result of this input beat
);

    cmd_t    cmd;
    status_t status;

    rsfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rsfr_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hdl/rsfr_ctrl.sv =====
// Sequencing state machine of the servo frame receiver: input handshake and result emission.
// Depends on rsfr_pkg.
`timescale 1ns / 1ps

module rsfr_ctrl
    import rsfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PUT1 = 4'b0010,
        S_READ = 4'b0100,
        S_PUTC = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd             = '0;
        cmd.accept      = s_tvalid && (state_reg == S_IDLE);
        cmd.rd          = (state_reg == S_READ);
        cmd.load_single = (state_reg == S_PUT1) && status.out_free;
        cmd.load_chan   = (state_reg == S_PUTC) && status.out_free;
        cmd.next_idx    = cmd.load_chan && !status.idx_last;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = status.good_frame ? S_READ : S_PUT1;
                end
            end
            S_PUT1: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                state_next = S_PUTC;
            end
            S_PUTC: begin
                if (status.out_free) begin
                    state_next = status.idx_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/rsfr_datapath.sv =====
// Frame parser, checksum, counters, payload memory, channel scaling and output register.
// Depends on rsfr_pkg.
`timescale 1ns / 1ps

module rsfr_datapath
    import rsfr_pkg::*;
#(
    parameter int NUM_CHANNELS = NumChannelsDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          s_tdata,
    input  logic [0:0]          s_tuser,
    input  cmd_t                cmd,
    output status_t             status,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,
    output logic [0:0]          m_tuser,
    output logic                m_tlast
);

    typedef enum logic [4:0] {
        P_LEN  = 5'b00001,
        P_TYPE = 5'b00010,
        P_DATA = 5'b00100,
        P_CKLO = 5'b01000,
        P_CKHI = 5'b10000
    } parse_t;

    localparam logic [ChanIdxW-1:0]    LastIdx  = ChanIdxW'(NUM_CHANNELS - 1);
    localparam logic [PayloadIdxW-1:0] LastByte = PayloadIdxW'(PayloadLen - 1);

    parse_t                 parse_reg, parse_next;
    logic [PayloadIdxW-1:0] pidx_reg, pidx_next;
    logic [15:0]            sum_reg, sum_next;
    logic [15:0]            seen_reg, seen_next;
    logic [15:0]            good_reg, good_next;
    logic [15:0]            fail_reg, fail_next;
    logic                   ok_reg, err_reg;
    logic                   frame_ok, frame_err;
    logic                   mem_we;
    logic [ChanIdxW-1:0]    idx_reg;
    logic [7:0]             rd_lo_reg, rd_hi_reg;
    logic [7:0]             payload_mem [PayloadLen];

    logic [15:0]            raw;
    logic signed [16:0]     diff;
    logic signed [16:0]     quot;

    logic                   valid_reg;
    logic [OutDataW-1:0]    data_reg;
    logic [0:0]             user_reg;
    logic                   last_reg;

    wire gap = (s_tuser[0] == FUNC_GAP);

    // Parser next state; only committed when a beat is accepted.
    always_comb begin
        parse_next = parse_reg;
        pidx_next  = pidx_reg;
        sum_next   = sum_reg;
        seen_next  = seen_reg;
        good_next  = good_reg;
        fail_next  = fail_reg;
        frame_ok   = 1'b0;
        frame_err  = 1'b0;
        mem_we     = 1'b0;
        if (gap) begin
            if (parse_reg != P_LEN) begin
                seen_next = seen_reg + 16'd1;
            end
            parse_next = P_LEN;
        end else begin
            unique case (parse_reg)
                P_LEN: begin
                    if (s_tdata == LEN_BYTE) begin
                        parse_next = P_TYPE;
                        sum_next   = SUM_START - {8'd0, s_tdata};
                    end
                end
                P_TYPE: begin
                    if (s_tdata == TYPE_BYTE) begin
                        sum_next   = sum_reg - {8'd0, s_tdata};
                        pidx_next  = '0;
                        parse_next = P_DATA;
                    end else if (s_tdata != LEN_BYTE) begin
                        parse_next = P_LEN;
                    end
                end
                P_DATA: begin
                    mem_we    = 1'b1;
                    pidx_next = pidx_reg + PayloadIdxW'(1);
                    sum_next  = sum_reg - {8'd0, s_tdata};
                    if (pidx_reg == LastByte) begin
                        parse_next = P_CKLO;
                    end
                end
                P_CKLO: begin
                    sum_next   = sum_reg - {8'd0, s_tdata};
                    parse_next = P_CKHI;
                end
                P_CKHI: begin
                    parse_next = P_LEN;
                    seen_next  = seen_reg + 16'd1;
                    if (sum_reg[7:0] == SUM_LO_OK && sum_reg[15:8] == s_tdata) begin
                        good_next = good_reg + 16'd1;
                        frame_ok  = 1'b1;
                    end else begin
                        fail_next = fail_reg + 16'd1;
                        frame_err = 1'b1;
                    end
                end
                default: begin
                    parse_next = P_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_reg <= P_LEN;
            pidx_reg  <= '0;
            sum_reg   <= '0;
            seen_reg  <= '0;
            good_reg  <= '0;
            fail_reg  <= '0;
            ok_reg    <= 1'b0;
            err_reg   <= 1'b0;
        end else if (cmd.accept) begin
            parse_reg <= parse_next;
            pidx_reg  <= pidx_next;
            sum_reg   <= sum_next;
            seen_reg  <= seen_next;
            good_reg  <= good_next;
            fail_reg  <= fail_next;
            ok_reg    <= frame_ok;
            err_reg   <= frame_err;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && mem_we) begin
            payload_mem[pidx_reg] <= s_tdata;
        end
        if (cmd.rd) begin
            rd_lo_reg <= payload_mem[{idx_reg, 1'b0}];
            rd_hi_reg <= payload_mem[{idx_reg, 1'b1}];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.accept) begin
            idx_reg <= '0;
        end else if (cmd.next_idx) begin
            idx_reg <= idx_reg + ChanIdxW'(1);
        end
    end

    // Arithmetic shift floors; a negative value with dropped bits is bumped toward zero.
    always_comb begin
        raw  = {rd_hi_reg, rd_lo_reg};
        diff = $signed(SCALE_BIAS) - $signed({1'b0, raw});
        quot = diff >>> 2;
        if (diff[16] && (diff[1:0] != 2'b00)) begin
            quot = quot + 17'sd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_single || cmd.load_chan) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_single) begin
            data_reg <= {2'b00, 8'd0, 16'd0, {ChanIdxW{1'b0}},
                         fail_reg, good_reg, seen_reg, err_reg, ok_reg};
            user_reg <= 1'b0;
            last_reg <= 1'b1;
        end else if (cmd.load_chan) begin
            data_reg <= {2'b00, quot[7:0], raw, idx_reg,
                         fail_reg, good_reg, seen_reg, 1'b0, 1'b1};
            user_reg <= 1'b1;
            last_reg <= (idx_reg == LastIdx);
        end
    end

    assign status.good_frame = frame_ok;
    assign status.idx_last   = (idx_reg == LastIdx);
    assign status.out_free   = !valid_reg || m_tready;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== hdl/rsfr_checker.sv =====
// Port-level checks for the servo frame receiver, bound to its top level.
// Depends on rsfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsfr_checker
    import rsfr_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata,
    input logic [0:0]          m_tuser,
    input logic                m_tlast
);

    // A stalled result beat must hold its contents.
    `ASSERT_CLK(a_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // A status-only beat is always the only result of its input beat.
    `ASSERT_CLK(a_status_last, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tlast)

    // Channel beats come only from a frame that passed its checksum.
    `ASSERT_CLK(a_chan_ok, aclk, aresetn, m_tvalid && m_tuser[0] |-> m_tdata[0] && !m_tdata[1])

    // An accepted input beat keeps the input closed while its results are produced.
    `ASSERT_CLK(a_accept_busy, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)

    // Reset empties the output register.
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind rc_servo_frame_receiver_core rsfr_checker u_rsfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/sv/testbench.sv =====
// Self-checking bench for rc_servo_frame_receiver_core: streams bytes and gap events in,
// predicts every status and channel beat, and checks the result stream in order.
// Depends on rsfr_pkg and the rc_servo_frame_receiver_core RTL.
`timescale 1ns / 1ps

module testbench;
    import rsfr_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_BEATS  = 140;

    typedef enum logic [4:0] {
        HUNT_LEN     = 5'b00001,
        WAIT_TYPE    = 5'b00010,
        TAKE_PAYLOAD = 5'b00100,
        TAKE_CK_LO   = 5'b01000,
        TAKE_CK_HI   = 5'b10000
    } rx_state_t;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_LO,
        FRAME_BAD_HI,
        FRAME_CUT
    } frame_kind_t;

    typedef struct packed {
        logic       func;
        logic [7:0] data;
    } rx_beat_t;

    typedef struct packed {
        logic        frame_ok;
        logic        checksum_error;
        logic [15:0] seen;
        logic [15:0] good;
        logic [15:0] fails;
        logic        chan_valid;
        logic [3:0]  chan_idx;
        logic [15:0] raw;
        logic [7:0]  scaled;
        logic        last;
    } servo_report_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;
    logic [0:0]          s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic [0:0]          m_tuser;
    logic                m_tlast;

    rx_beat_t      rx_beat_q[$];
    servo_report_t servo_report_q[$];
    int            queued_beats = 0;
    int            faults       = 0;
    int            quiet_cycles = 0;
    bit            no_idle      = 1'b0;

    // Shadow of the receiver state, advanced on every accepted input beat.
    rx_state_t   rx_state = HUNT_LEN;
    logic [4:0]  rx_idx   = '0;
    logic [15:0] rx_sum   = '0;
    logic [7:0]  rx_payload [PayloadLen];
    logic [15:0] cnt_seen = '0;
    logic [15:0] cnt_good = '0;
    logic [15:0] cnt_fail = '0;

    rc_servo_frame_receiver_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void parse_rx_beat(input logic func, input logic [7:0] b);
        servo_report_t rep;
        logic          ok;
        logic          err;
        logic [15:0]   raw;
        int            q;
        ok  = 1'b0;
        err = 1'b0;
        if (func == FUNC_GAP) begin
            if (rx_state != HUNT_LEN) cnt_seen++;
            rx_state = HUNT_LEN;
        end else begin
            case (rx_state)
                HUNT_LEN: begin
                    if (b == LEN_BYTE) begin
                        rx_state = WAIT_TYPE;
                        rx_sum   = SUM_START - b;
                    end
                end
                WAIT_TYPE: begin
                    if (b == TYPE_BYTE) begin
                        rx_sum   = rx_sum - b;
                        rx_idx   = '0;
                        rx_state = TAKE_PAYLOAD;
                    end else if (b != LEN_BYTE) begin
                        rx_state = HUNT_LEN;
                    end
                end
                TAKE_PAYLOAD: begin
                    rx_payload[rx_idx] = b;
                    rx_idx = rx_idx + 1'b1;
                    rx_sum = rx_sum - b;
                    if (rx_idx == PayloadLen) rx_state = TAKE_CK_LO;
                end
                TAKE_CK_LO: begin
                    rx_sum   = rx_sum - b;
                    rx_state = TAKE_CK_HI;
                end
                default: begin
                    rx_state = HUNT_LEN;
                    cnt_seen++;
                    if (rx_sum[7:0] == SUM_LO_OK && rx_sum[15:8] == b) begin
                        cnt_good++;
                        ok = 1'b1;
                    end else begin
                        cnt_fail++;
                        err = 1'b1;
                    end
                end
            endcase
        end

        rep                = '0;
        rep.frame_ok       = ok;
        rep.checksum_error = err;
        rep.seen           = cnt_seen;
        rep.good           = cnt_good;
        rep.fails          = cnt_fail;
        rep.last           = 1'b1;
        if (ok) begin
            for (int i = 0; i < NumChannelsDefault; i++) begin
                raw            = {rx_payload[2*i+1], rx_payload[2*i]};
                // Signed division truncates toward zero, as the block must.
                q              = (int'(SCALE_BIAS) - int'(raw)) / 4;
                rep.chan_valid = 1'b1;
                rep.chan_idx   = i[3:0];
                rep.raw        = raw;
                rep.scaled     = q[7:0];
                rep.last       = (i == NumChannelsDefault - 1);
                servo_report_q.push_back(rep);
            end
        end else begin
            servo_report_q.push_back(rep);
        end
    endfunction

    function automatic bit same_report(input servo_report_t a, input servo_report_t b);
        return a.frame_ok === b.frame_ok && a.checksum_error === b.checksum_error
            && a.seen === b.seen && a.good === b.good && a.fails === b.fails
            && a.chan_valid === b.chan_valid && a.chan_idx === b.chan_idx
            && a.raw === b.raw && a.scaled === b.scaled && a.last === b.last;
    endfunction

    function automatic string show_report(input servo_report_t r);
        return $sformatf("ok=%b err=%b seen=%0d good=%0d fail=%0d cv=%b idx=%0d raw=%h %s",
                         r.frame_ok, r.checksum_error, r.seen, r.good, r.fails,
                         r.chan_valid, r.chan_idx, r.raw,
                         $sformatf("sc=%h last=%b", r.scaled, r.last));
    endfunction

    task automatic push_beat(input logic func, input logic [7:0] data);
        rx_beat_t beat;
        beat.func = func;
        beat.data = data;
        rx_beat_q.push_back(beat);
        queued_beats++;
    endtask

    // One frame with optional repeated length bytes; edge_values fills the channels
    // with zero, full scale and the points where the scaled value rounds or wraps.
    task automatic queue_frame(input frame_kind_t kind, input bit edge_values);
        logic [7:0]  seq [$];
        logic [15:0] csum;
        logic [15:0] raw;
        logic [7:0]  ck_lo;
        logic [7:0]  ck_hi;
        int          cut_at;
        seq.push_back(LEN_BYTE);
        repeat (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0) seq.push_back(LEN_BYTE);
        seq.push_back(TYPE_BYTE);
        csum = SUM_START - LEN_BYTE - TYPE_BYTE;
        for (int i = 0; i < PayloadLen / 2; i++) begin
            if (edge_values) begin
                case (i)
                    0:       raw = 16'h0000;
                    1:       raw = 16'hFFFF;
                    2:       raw = 16'd1500;
                    3:       raw = 16'd1503;
                    4:       raw = 16'd1504;
                    5:       raw = 16'd1497;
                    6:       raw = 16'd1496;
                    7:       raw = 16'd992;
                    8:       raw = 16'd991;
                    9:       raw = 16'd2012;
                    10:      raw = 16'd2013;
                    11:      raw = 16'h8000;
                    12:      raw = 16'h7FFF;
                    default: raw = 16'd988;
                endcase
            end else begin
                case ($urandom_range(4))
                    0:       raw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    1:       raw = 16'($urandom_range(1504, 1496));
                    2:       raw = 16'($urandom_range(2012, 988));
                    default: raw = 16'($urandom);
                endcase
            end
            seq.push_back(raw[7:0]);
            seq.push_back(raw[15:8]);
            csum = csum - raw[7:0] - raw[15:8];
        end
        ck_lo = csum[7:0];
        ck_hi = csum[15:8];
        if (kind == FRAME_BAD_LO) ck_lo = ck_lo ^ 8'($urandom_range(255, 1));
        if (kind == FRAME_BAD_HI) ck_hi = ck_hi ^ 8'($urandom_range(255, 1));
        seq.push_back(ck_lo);
        seq.push_back(ck_hi);
        cut_at = (kind == FRAME_CUT) ? $urandom_range(seq.size() - 1, 1) : seq.size();
        for (int i = 0; i < cut_at; i++) push_beat(FUNC_BYTE, seq[i]);
        if (kind == FRAME_CUT) push_beat(FUNC_GAP, 8'($urandom));
    endtask

    task automatic wait_drained();
        while (rx_beat_q.size() != 0 || s_tvalid || servo_report_q.size() != 0)
            @(negedge aclk);
    endtask

    always @(posedge aclk) begin : beat_driver
        rx_beat_t beat;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (rx_beat_q.size() != 0 && (no_idle || $urandom_range(99) >= 19)) begin
                beat      = rx_beat_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= beat.data;
                s_tuser  <= beat.func;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= aresetn && (no_idle || $urandom_range(99) >= 19);
    end

    always @(posedge aclk) begin : report_monitor
        servo_report_t got;
        servo_report_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) parse_rx_beat(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) begin
                got.frame_ok       = m_tdata[0];
                got.checksum_error = m_tdata[1];
                got.seen           = m_tdata[17:2];
                got.good           = m_tdata[33:18];
                got.fails          = m_tdata[49:34];
                got.chan_idx       = m_tdata[53:50];
                got.raw            = m_tdata[69:54];
                got.scaled         = m_tdata[77:70];
                got.chan_valid     = m_tuser[0];
                got.last           = m_tlast;
                if (servo_report_q.size() == 0) begin
                    faults++;
                    if (faults <= 10) $display("unexpected result beat: %s", show_report(got));
                end else begin
                    want = servo_report_q.pop_front();
                    if (!same_report(got, want)) begin
                        faults++;
                        if (faults <= 10) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected %s", show_report(want));
                            $display("  actual   %s", show_report(got));
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("rc_servo_frame_receiver_core verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int base;
        int stage;
        int pick;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Hunting ignores gaps and stray bytes, the type byte included.
        push_beat(FUNC_GAP, 8'h00);
        push_beat(FUNC_BYTE, 8'h00);
        push_beat(FUNC_BYTE, 8'hFF);
        push_beat(FUNC_BYTE, TYPE_BYTE);
        // Repeated length bytes keep waiting; a wrong type restarts the hunt.
        push_beat(FUNC_BYTE, LEN_BYTE);
        push_beat(FUNC_BYTE, LEN_BYTE);
        push_beat(FUNC_BYTE, LEN_BYTE);
        push_beat(FUNC_BYTE, 8'h41);
        // A gap while waiting for the type aborts a frame.
        push_beat(FUNC_BYTE, LEN_BYTE);
        push_beat(FUNC_GAP, 8'hFF);
        // A gap in mid-payload aborts a frame; a second gap does nothing.
        push_beat(FUNC_BYTE, LEN_BYTE);
        push_beat(FUNC_BYTE, TYPE_BYTE);
        push_beat(FUNC_BYTE, 8'h00);
        push_beat(FUNC_BYTE, 8'hFF);
        push_beat(FUNC_GAP, 8'h00);
        push_beat(FUNC_GAP, 8'h55);
        wait_drained();

        base  = queued_beats;
        stage = 0;
        queue_frame(FRAME_GOOD, 1'b1);
        queue_frame(FRAME_BAD_LO, 1'b0);
        queue_frame(FRAME_BAD_HI, 1'b0);
        while (queued_beats - base < RANDOM_BEATS) begin
            if (stage == 0 && queued_beats - base >= 70) begin
                // Hold the sender back until every result is out, then run unthrottled.
                wait_drained();
                no_idle = 1'b1;
                stage   = 1;
            end else if (stage == 1 && queued_beats - base >= 130) begin
                // Let the unthrottled stretch play out before idling resumes.
                wait_drained();
                no_idle = 1'b0;
                stage   = 2;
            end
            pick = $urandom_range(99);
            if (pick < 55)
                queue_frame(FRAME_GOOD, 1'b0);
            else if (pick < 63)
                queue_frame(FRAME_BAD_LO, 1'b0);
            else if (pick < 70)
                queue_frame(FRAME_BAD_HI, 1'b0);
            else if (pick < 82)
                queue_frame(FRAME_CUT, 1'b0);
            else
                repeat ($urandom_range(3, 1))
                    push_beat(($urandom_range(3) == 0) ? FUNC_GAP : FUNC_BYTE, 8'($urandom));
        end
        no_idle = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (faults == 0 && servo_report_q.size() == 0)
            $display("rc_servo_frame_receiver_core verification clean");
        else
            $display("rc_servo_frame_receiver_core verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rsfr_pkg.sv
hdl/rsfr_ctrl.sv
hdl/rsfr_datapath.sv
hdl/rc_servo_frame_receiver_core.sv
hdl/rsfr_checker.sv
tb/sv/testbench.sv
